// ===== hdl/bda_pkg.sv =====
// Package for the deadlock-avoidance engine: sizes, status and command codes,
// shared types. No dependencies.
`default_nettype none
package bda_pkg;
    localparam int MAX_PROCS_DEF = 8;
    localparam int MAX_TYPES_DEF = 4;
    localparam int UNIT_BITS_DEF = 8;
    localparam int NUM_TOTALS    = 4;

    localparam logic [1:0] CMD_CLAIM = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_REQ   = 2'd3;

    localparam logic [2:0] ST_LOADED         = 3'd0;
    localparam logic [2:0] ST_CLAIM_GT_TOTAL = 3'd1;
    localparam logic [2:0] ST_ALLOC_GT_CLAIM = 3'd2;
    localparam logic [2:0] ST_SAFE           = 3'd3;
    localparam logic [2:0] ST_UNSAFE         = 3'd4;
    localparam logic [2:0] ST_ALLOC_GT_TOTAL = 3'd5;
    localparam logic [2:0] ST_REQ_GT_NEED    = 3'd6;
    localparam logic [2:0] ST_WAIT           = 3'd7;

    localparam logic [2:0] CFG_NUM_PROCS = 3'd0;
    localparam logic [2:0] CFG_NUM_TYPES = 3'd1;
    localparam logic [2:0] CFG_TOTAL0    = 3'd2;
    localparam logic [2:0] CFG_TOTAL3    = 3'd5;

    // per-lane verdict handed to the merge stage
    typedef struct packed {
        logic fits;    // need <= work for this type (or type unused)
    } lane_res_t;
endpackage
`default_nettype wire

// ===== hdl/bankers_deadlock_avoidance.sv =====
// Top level of the banker's deadlock-avoidance engine: tables, sequencer,
// type lanes and result output. Depends on bda_pkg, bda_lane, bda_merge.
//
//  channel   dir  fields
//  s_axis    in   tuser=command, tdata=process,units_type0..3
//  m_axis    out  tuser=status, tdata=safe_process, tlast=last
//  cfg       in   cfg_we, cfg_index, cfg_data
//
// Load: one status item. Check: a row sweep of the tables (np = processes
// in use, at most MAX_PROCS), then the safety walk, one process visited per
// cycle with all type lanes compared at once, np passes of np visits, then
// the results. Request: bound tests, walk, results. Tables reset to zero.
// Output stalls hold the sequencer; s_axis_tready is high only while idle.
`default_nettype none
module bankers_deadlock_avoidance #(
    parameter int MAX_PROCS = bda_pkg::MAX_PROCS_DEF,
    parameter int MAX_TYPES = bda_pkg::MAX_TYPES_DEF,
    parameter int UNIT_BITS = bda_pkg::UNIT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // process[2:0], units_type0..3 [10:3]..[34:27]
    input  wire logic [1:0]  s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // safe_process[2:0]
    output logic [2:0]       m_axis_tuser,   // status
    output logic             m_axis_tlast
);
    import bda_pkg::*;

    localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CB = $clog2(MAX_PROCS + 1);
    localparam int SB = $clog2(MAX_PROCS * MAX_PROCS + 1);
    localparam logic [UNIT_BITS-1:0] UMAX = {UNIT_BITS{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ONE   = 3'd4;
    localparam logic [2:0] S_REQ   = 3'd5;

    logic [2:0] state_reg;
    logic [3:0] num_procs_reg;
    logic [2:0] num_types_reg;
    logic [7:0] total_reg [NUM_TOTALS];

    logic [UNIT_BITS-1:0] claim_reg [MAX_PROCS][MAX_TYPES];
    logic [UNIT_BITS-1:0] alloc_reg [MAX_PROCS][MAX_TYPES];
    logic [UNIT_BITS-1:0] need_reg  [MAX_PROCS][MAX_TYPES];
    logic [UNIT_BITS-1:0] avail_reg [MAX_TYPES];
    // tentative copies used by the walk
    logic [UNIT_BITS-1:0] talloc_reg [MAX_PROCS][MAX_TYPES];
    logic [UNIT_BITS-1:0] tneed_reg  [MAX_PROCS][MAX_TYPES];
    logic [UNIT_BITS-1:0] tavail_reg [MAX_TYPES];
    logic [UNIT_BITS-1:0] work_reg   [MAX_TYPES];
    logic [UNIT_BITS+PB:0] sum_reg   [MAX_TYPES];
    logic [MAX_PROCS-1:0] fin_reg;
    logic [PB-1:0]        order_reg [MAX_PROCS];

    logic [1:0]  cmd_reg;
    logic [PB-1:0] proc_reg;
    logic [UNIT_BITS-1:0] units_reg [MAX_TYPES];
    logic [CB-1:0] idx_reg;       // sweep row / emit index
    logic [CB-1:0] cnt_reg;
    logic [SB-1:0] step_reg;
    logic [PB-1:0] wp_reg;        // walk process pointer
    logic        bad_reg;
    logic [2:0]  status_reg;

    logic [CB-1:0] np;
    logic [2:0]    nt;
    always_comb
    begin
        np = (num_procs_reg == 4'd0) ? CB'(1)
           : (32'(num_procs_reg) > MAX_PROCS) ? CB'(MAX_PROCS) : CB'(num_procs_reg);
        nt = (num_types_reg == 3'd0) ? 3'd1
           : (32'(num_types_reg) > MAX_TYPES) ? 3'(MAX_TYPES) : num_types_reg;
    end

    function automatic logic [UNIT_BITS-1:0] total_of(input int t, input logic [7:0] v);
        logic [UNIT_BITS-1:0] r;
        r = '0;
        if (t < NUM_TOTALS)
        begin
            if (UNIT_BITS >= 8) r = UNIT_BITS'(v);
            else r = v[UNIT_BITS-1:0];
        end
        return r;
    endfunction

    logic [UNIT_BITS-1:0] in_units [MAX_TYPES];
    always_comb
    begin
        for (int t = 0; t < MAX_TYPES; t++)
        begin
            if (t < NUM_TOTALS)
            begin
                if (UNIT_BITS >= 8) in_units[t] = UNIT_BITS'(s_axis_tdata[3+8*t +: 8]);
                else in_units[t] = s_axis_tdata[3+8*t +: UNIT_BITS];
            end
            else in_units[t] = '0;
        end
    end

    // lanes
    lane_res_t [MAX_TYPES-1:0] lres;
    logic [UNIT_BITS-1:0] wsum [MAX_TYPES];
    logic all_fit;
    genvar g;
    generate
        for (g = 0; g < MAX_TYPES; g++)
        begin : g_lane
            bda_lane #(.UNIT_BITS(UNIT_BITS)) u_lane (
                .in_use  (g < nt),
                .need    (tneed_reg[wp_reg][g]),
                .work    (work_reg[g]),
                .alloc   (talloc_reg[wp_reg][g]),
                .res     (lres[g]),
                .work_sum(wsum[g])
            );
        end
    endgenerate
    bda_merge #(.MAX_TYPES(MAX_TYPES)) u_merge (.res(lres), .all_fit(all_fit));

    // load-time checks
    logic load_ok;
    logic req_need_ok, req_av_ok;
    logic row_stale;
    always_comb
    begin
        load_ok = 1'b1;
        req_need_ok = 1'b1;
        req_av_ok = 1'b1;
        row_stale = 1'b0;
        for (int t = 0; t < MAX_TYPES; t++)
        begin
            if (t < nt)
            begin
                if (cmd_reg == CMD_CLAIM && units_reg[t] > total_of(t, total_reg[t % NUM_TOTALS]))
                    load_ok = 1'b0;
                if (cmd_reg == CMD_ALLOC && units_reg[t] > claim_reg[proc_reg][t])
                    load_ok = 1'b0;
                if (units_reg[t] > need_reg[proc_reg][t]) req_need_ok = 1'b0;
                if (units_reg[t] > avail_reg[t]) req_av_ok = 1'b0;
                if (alloc_reg[PB'(idx_reg)][t] > claim_reg[PB'(idx_reg)][t])
                    row_stale = 1'b1;
            end
        end
    end

    logic out_fire;
    assign out_fire = ((state_reg == S_EMIT) || (state_reg == S_ONE))
                    && (!m_axis_tvalid || m_axis_tready);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_procs_reg <= 4'd1;
            num_types_reg <= 3'd1;
            for (int t = 0; t < NUM_TOTALS; t++) total_reg[t] <= '0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                for (int t = 0; t < MAX_TYPES; t++)
                begin
                    claim_reg[i][t] <= '0;
                    alloc_reg[i][t] <= '0;
                    need_reg[i][t]  <= '0;
                end
            end
            for (int t = 0; t < MAX_TYPES; t++) avail_reg[t] <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index) inside
                    CFG_NUM_PROCS: num_procs_reg <= cfg_data[3:0];
                    CFG_NUM_TYPES: num_types_reg <= cfg_data[2:0];
                    [CFG_TOTAL0:CFG_TOTAL3]: total_reg[2'(cfg_index - CFG_TOTAL0)] <= cfg_data;
                    default: ;
                endcase
            end
            if (out_fire) m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg  <= s_axis_tuser;
                        proc_reg <= PB'(s_axis_tdata[2:0]);
                        for (int t = 0; t < MAX_TYPES; t++) units_reg[t] <= in_units[t];
                        // process index beyond table: load ignored
                        bad_reg  <= (32'(s_axis_tdata[2:0]) >= MAX_PROCS);
                        idx_reg  <= '0;
                        for (int t = 0; t < MAX_TYPES; t++) sum_reg[t] <= '0;
                        status_reg <= ST_LOADED;
                        unique case (s_axis_tuser)
                            CMD_CHECK: state_reg <= S_CHK;
                            CMD_REQ:   state_reg <= S_REQ;
                            default:   state_reg <= S_ONE;
                        endcase
                        if (s_axis_tuser == CMD_REQ && 32'(s_axis_tdata[2:0]) >= 32'(np))
                            bad_reg <= 1'b1;
                    end
                end
                S_CHK:
                begin
                    // one process row per cycle: stale-claim test and column sums
                    if (idx_reg < np)
                    begin
                        if (row_stale)
                            status_reg <= ST_ALLOC_GT_CLAIM;
                        for (int t = 0; t < MAX_TYPES; t++)
                            sum_reg[t] <= sum_reg[t] + (UNIT_BITS+PB+1)'(alloc_reg[PB'(idx_reg)][t]);
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (status_reg == ST_ALLOC_GT_CLAIM)
                        state_reg <= S_ONE;
                    else
                    begin
                        logic over;
                        over = 1'b0;
                        for (int t = 0; t < MAX_TYPES; t++)
                            if (t < nt && sum_reg[t] > (UNIT_BITS+PB+1)'(total_of(t, total_reg[t % NUM_TOTALS])))
                                over = 1'b1;
                        if (over)
                        begin
                            status_reg <= ST_ALLOC_GT_TOTAL;
                            state_reg  <= S_ONE;
                        end
                        else
                        begin
                            for (int t = 0; t < MAX_TYPES; t++)
                            begin
                                if (t < nt)
                                begin
                                    avail_reg[t]  <= total_of(t, total_reg[t % NUM_TOTALS]) - UNIT_BITS'(sum_reg[t]);
                                    tavail_reg[t] <= total_of(t, total_reg[t % NUM_TOTALS]) - UNIT_BITS'(sum_reg[t]);
                                    work_reg[t]   <= total_of(t, total_reg[t % NUM_TOTALS]) - UNIT_BITS'(sum_reg[t]);
                                end
                                else
                                begin
                                    tavail_reg[t] <= avail_reg[t];
                                    work_reg[t]   <= avail_reg[t];
                                end
                            end
                            for (int i = 0; i < MAX_PROCS; i++)
                            begin
                                for (int t = 0; t < MAX_TYPES; t++)
                                begin
                                    talloc_reg[i][t] <= alloc_reg[i][t];
                                    if (i < np && t < nt)
                                    begin
                                        need_reg[i][t]  <= claim_reg[i][t] - alloc_reg[i][t];
                                        tneed_reg[i][t] <= claim_reg[i][t] - alloc_reg[i][t];
                                    end
                                    else
                                        tneed_reg[i][t] <= need_reg[i][t];
                                end
                            end
                            fin_reg  <= '0;
                            cnt_reg  <= '0;
                            wp_reg   <= '0;
                            step_reg <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_REQ:
                begin
                    if (bad_reg || !req_need_ok)
                    begin
                        status_reg <= ST_REQ_GT_NEED;
                        state_reg  <= S_ONE;
                    end
                    else if (!req_av_ok)
                    begin
                        status_reg <= ST_WAIT;
                        state_reg  <= S_ONE;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_PROCS; i++)
                        begin
                            for (int t = 0; t < MAX_TYPES; t++)
                            begin
                                if (PB'(i) == proc_reg && t < nt)
                                begin
                                    logic [UNIT_BITS:0] s;
                                    s = {1'b0, alloc_reg[i][t]} + {1'b0, units_reg[t]};
                                    talloc_reg[i][t] <= s[UNIT_BITS] ? UMAX : s[UNIT_BITS-1:0];
                                    tneed_reg[i][t]  <= need_reg[i][t] - units_reg[t];
                                end
                                else
                                begin
                                    talloc_reg[i][t] <= alloc_reg[i][t];
                                    tneed_reg[i][t]  <= need_reg[i][t];
                                end
                            end
                        end
                        for (int t = 0; t < MAX_TYPES; t++)
                        begin
                            if (t < nt)
                            begin
                                tavail_reg[t] <= avail_reg[t] - units_reg[t];
                                work_reg[t]   <= avail_reg[t] - units_reg[t];
                            end
                            else
                            begin
                                tavail_reg[t] <= avail_reg[t];
                                work_reg[t]   <= avail_reg[t];
                            end
                        end
                        fin_reg  <= '0;
                        cnt_reg  <= '0;
                        wp_reg   <= '0;
                        step_reg <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // visit one process per cycle, np passes of np visits
                    if (!fin_reg[wp_reg] && all_fit)
                    begin
                        fin_reg[wp_reg] <= 1'b1;
                        for (int t = 0; t < MAX_TYPES; t++)
                            if (t < nt) work_reg[t] <= wsum[t];
                        order_reg[PB'(cnt_reg)] <= wp_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (CB'(wp_reg) + 1'b1 == np) wp_reg <= '0;
                    else wp_reg <= wp_reg + 1'b1;
                    if (step_reg + 1'b1 == SB'(np) * SB'(np))
                    begin
                        logic [CB-1:0] fc;
                        fc = cnt_reg + CB'(!fin_reg[wp_reg] && all_fit);
                        idx_reg <= '0;
                        if (fc != np)
                        begin
                            status_reg <= ST_UNSAFE;
                            state_reg  <= S_ONE;
                        end
                        else
                        begin
                            if (cmd_reg == CMD_REQ)
                            begin
                                for (int t = 0; t < MAX_TYPES; t++) avail_reg[t] <= tavail_reg[t];
                                for (int i = 0; i < MAX_PROCS; i++)
                                begin
                                    for (int t = 0; t < MAX_TYPES; t++)
                                    begin
                                        alloc_reg[i][t] <= talloc_reg[i][t];
                                        need_reg[i][t]  <= tneed_reg[i][t];
                                    end
                                end
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_fire)
                    begin
                        m_axis_tuser  <= ST_SAFE;
                        m_axis_tdata  <= 8'(order_reg[PB'(idx_reg)]);
                        m_axis_tlast  <= (idx_reg + 1'b1 == np);
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == np) state_reg <= S_IDLE;
                    end
                end
                S_ONE:
                begin
                    if (out_fire)
                    begin
                        if (status_reg == ST_LOADED && !bad_reg && load_ok
                            && cmd_reg == CMD_CLAIM)
                            for (int t = 0; t < MAX_TYPES; t++) claim_reg[proc_reg][t] <= units_reg[t];
                        if (status_reg == ST_LOADED && !bad_reg && load_ok
                            && cmd_reg == CMD_ALLOC)
                            for (int t = 0; t < MAX_TYPES; t++) alloc_reg[proc_reg][t] <= units_reg[t];
                        m_axis_tdata  <= '0;
                        m_axis_tlast  <= 1'b1;
                        if (status_reg == ST_LOADED && !bad_reg && !load_ok)
                            m_axis_tuser <= (cmd_reg == CMD_CLAIM) ? ST_CLAIM_GT_TOTAL
                                                                   : ST_ALLOC_GT_CLAIM;
                        else
                            m_axis_tuser <= status_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/bda_lane.sv =====
// One resource-type lane: compares need against work and forms the
// saturated work update. Depends on bda_pkg.
`default_nettype none
module bda_lane #(
    parameter int UNIT_BITS = bda_pkg::UNIT_BITS_DEF
) (
    input  wire logic                 in_use,
    input  wire logic [UNIT_BITS-1:0] need,
    input  wire logic [UNIT_BITS-1:0] work,
    input  wire logic [UNIT_BITS-1:0] alloc,
    output bda_pkg::lane_res_t        res,
    output logic [UNIT_BITS-1:0]      work_sum
);
    import bda_pkg::*;
    logic [UNIT_BITS:0] sum;
    assign sum      = {1'b0, work} + {1'b0, alloc};
    assign work_sum = sum[UNIT_BITS] ? {UNIT_BITS{1'b1}} : sum[UNIT_BITS-1:0];
    assign res.fits = !in_use || (need <= work);
endmodule
`default_nettype wire

// ===== hdl/bda_merge.sv =====
// Merge stage: ANDs the lane verdicts into one process-ready flag.
// Depends on bda_pkg.
`default_nettype none
module bda_merge #(
    parameter int MAX_TYPES = bda_pkg::MAX_TYPES_DEF
) (
    input  bda_pkg::lane_res_t [MAX_TYPES-1:0] res,
    output logic                               all_fit
);
    import bda_pkg::*;
    always_comb
    begin
        all_fit = 1'b1;
        for (int t = 0; t < MAX_TYPES; t++)
        begin
            all_fit = all_fit & res[t].fits;
        end
    end
endmodule
`default_nettype wire

// ===== tb/bda_checker.sv =====
// Checker for the deadlock-avoidance engine: watches the config port and both
// streams, predicts the result items and compares them. Depends on bda_pkg.
module bda_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);
    import bda_pkg::*;

    localparam int NP = MAX_PROCS_DEF;
    localparam int NT = MAX_TYPES_DEF;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] proc_id;
        logic       last;
    } outcome_t;

    outcome_t  awaited[$];
    logic [3:0] procs_reg;
    logic [2:0] types_reg;
    logic [7:0] totals [NT];
    logic [7:0] claim [NP][NT];
    logic [7:0] alloc [NP][NT];
    logic [7:0] need [NP][NT];
    logic [7:0] avail [NT];
    logic [2:0] order [NP];

    function automatic int procs_in_use();
        if (procs_reg < 1) return 1;
        return procs_reg > NP ? NP : int'(procs_reg);
    endfunction

    function automatic int types_in_use();
        if (types_reg < 1) return 1;
        return types_reg > NT ? NT : int'(types_reg);
    endfunction

    function automatic logic [7:0] sum_sat(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = a + b;
        return s[8] ? 8'hff : s[7:0];
    endfunction

    // fills order[], returns how many processes finished
    function automatic int walk_safe(logic [7:0] av [NT], logic [7:0] al [NP][NT],
                                     logic [7:0] nd [NP][NT]);
        logic [7:0] work [NT];
        logic       done [NP];
        int np, nt, cnt;
        logic ok;
        np = procs_in_use();
        nt = types_in_use();
        cnt = 0;
        work = av;
        for (int i = 0; i < NP; i++) done[i] = 0;
        for (int pass = 0; pass < np; pass++)
            for (int i = 0; i < np; i++)
            begin
                if (done[i]) continue;
                ok = 1;
                for (int j = 0; j < nt; j++) if (nd[i][j] > work[j]) ok = 0;
                if (ok)
                begin
                    done[i] = 1;
                    for (int j = 0; j < nt; j++) work[j] = sum_sat(work[j], al[i][j]);
                    order[cnt] = i[2:0];
                    cnt++;
                end
            end
        return cnt;
    endfunction

    function automatic void push_one(logic [2:0] st);
        outcome_t o;
        o.status = st;
        o.proc_id = 0;
        o.last = 1;
        awaited.push_back(o);
    endfunction

    function automatic void push_order(int cnt);
        outcome_t o;
        for (int k = 0; k < cnt; k++)
        begin
            o.status = ST_SAFE;
            o.proc_id = order[k];
            o.last = (k == cnt - 1);
            awaited.push_back(o);
        end
    endfunction

    function automatic void predict_item(logic [1:0] cmd, logic [39:0] d);
        logic [2:0] p;
        logic [7:0] u [NT];
        logic [7:0] av [NT];
        logic [7:0] al [NP][NT];
        logic [7:0] nd [NP][NT];
        int np, nt, cnt, sum;
        p = d[2:0];
        for (int t = 0; t < NT; t++) u[t] = d[3 + 8*t +: 8];
        np = procs_in_use();
        nt = types_in_use();
        if (cmd == CMD_CLAIM || cmd == CMD_ALLOC)
        begin
            for (int t = 0; t < nt; t++)
            begin
                if (cmd == CMD_CLAIM && u[t] > totals[t])
                begin
                    push_one(ST_CLAIM_GT_TOTAL);
                    return;
                end
                if (cmd == CMD_ALLOC && u[t] > claim[p][t])
                begin
                    push_one(ST_ALLOC_GT_CLAIM);
                    return;
                end
            end
            for (int t = 0; t < NT; t++)
                if (cmd == CMD_CLAIM) claim[p][t] = u[t];
                else alloc[p][t] = u[t];
            push_one(ST_LOADED);
            return;
        end
        if (cmd == CMD_CHECK)
        begin
            for (int i = 0; i < np; i++)
                for (int t = 0; t < nt; t++)
                    if (alloc[i][t] > claim[i][t])
                    begin
                        push_one(ST_ALLOC_GT_CLAIM);
                        return;
                    end
            for (int t = 0; t < nt; t++)
            begin
                sum = 0;
                for (int i = 0; i < np; i++) sum += alloc[i][t];
                if (sum > totals[t])
                begin
                    push_one(ST_ALLOC_GT_TOTAL);
                    return;
                end
                av[t] = totals[t] - sum[7:0];
            end
            for (int t = 0; t < nt; t++) avail[t] = av[t];
            for (int i = 0; i < np; i++)
                for (int t = 0; t < nt; t++) need[i][t] = claim[i][t] - alloc[i][t];
            cnt = walk_safe(avail, alloc, need);
            if (cnt != np) push_one(ST_UNSAFE);
            else push_order(cnt);
            return;
        end
        if (p >= np)
        begin
            push_one(ST_REQ_GT_NEED);
            return;
        end
        for (int t = 0; t < nt; t++)
            if (u[t] > need[p][t])
            begin
                push_one(ST_REQ_GT_NEED);
                return;
            end
        for (int t = 0; t < nt; t++)
            if (u[t] > avail[t])
            begin
                push_one(ST_WAIT);
                return;
            end
        av = avail;
        al = alloc;
        nd = need;
        for (int t = 0; t < nt; t++)
        begin
            av[t] = av[t] - u[t];
            al[p][t] = sum_sat(al[p][t], u[t]);
            nd[p][t] = nd[p][t] - u[t];
        end
        cnt = walk_safe(av, al, nd);
        if (cnt != np)
        begin
            push_one(ST_UNSAFE);
            return;
        end
        avail = av;
        alloc = al;
        need = nd;
        push_order(cnt);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            procs_reg <= 1;
            types_reg <= 1;
            errors <= 0;
            awaited.delete();
            for (int t = 0; t < NT; t++)
            begin
                totals[t] = 0;
                avail[t] = 0;
                for (int i = 0; i < NP; i++)
                begin
                    claim[i][t] = 0;
                    alloc[i][t] = 0;
                    need[i][t] = 0;
                end
            end
        end
        else
        begin
            // results first: the item accepted now cannot have produced any yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result item: status %0d proc %0d last %0d",
                                 m_axis_tuser, m_axis_tdata[2:0], m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== {5'b0, want.proc_id}
                        || m_axis_tlast !== want.last)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected status %0d proc %0d last %0d, got %0d %0d %0d",
                                     want.status, want.proc_id, want.last,
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
            if (cfg_we)
            begin
                if (cfg_index == CFG_NUM_PROCS) procs_reg <= cfg_data[3:0];
                else if (cfg_index == CFG_NUM_TYPES) types_reg <= cfg_data[2:0];
                else if (cfg_index >= CFG_TOTAL0 && cfg_index <= CFG_TOTAL3)
                    totals[2'(cfg_index - CFG_TOTAL0)] = cfg_data;
            end
        end
        pending <= awaited.size();
    end
endmodule

// ===== tb/testbench.sv =====
// Testbench top for bankers_deadlock_avoidance: clock, reset, config writes,
// directed and random items, idling. Depends on bda_pkg and bda_checker.
module testbench;
    import bda_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = 0;
    logic [7:0]  cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          quiet_cycles = 0;
    int          sent_count = 0;
    logic [7:0]  tot [4];
    int          nprocs;

    localparam int WATCHDOG = 20000;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    bankers_deadlock_avoidance DUT (.*);

    bda_checker checker_i (.*);

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // tvalid stays high after the handshake until the next item or a drain
    task automatic send_item(logic [1:0] cmd, logic [2:0] p, logic [7:0] u0, logic [7:0] u1,
                             logic [7:0] u2, logic [7:0] u3);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'b0, u3, u2, u1, u0, p};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_count++;
    endtask

    // wait for all results plus the longest walk, so a config write finds it idle
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] np, logic [2:0] nt, logic [7:0] t0, logic [7:0] t1,
                              logic [7:0] t2, logic [7:0] t3);
        drain();
        write_reg(CFG_NUM_PROCS, {4'd0, np});
        write_reg(CFG_NUM_TYPES, {5'd0, nt});
        write_reg(CFG_TOTAL0, t0);
        write_reg(CFG_TOTAL0 + 3'd1, t1);
        write_reg(CFG_TOTAL0 + 3'd2, t2);
        write_reg(CFG_TOTAL3, t3);
        cfg_we <= 0;
        tot[0] = t0; tot[1] = t1; tot[2] = t2; tot[3] = t3;
        nprocs = (np == 0) ? 1 : (np > 8 ? 8 : int'(np));
    endtask

    function automatic logic [7:0] frac(logic [7:0] lim);
        return 8'($urandom_range(lim));
    endfunction

    // a round: well-formed claims, allocations, a check, then mostly requests
    task automatic scenario();
        logic [7:0] c [8][4];
        for (int i = 0; i < nprocs; i++)
        begin
            for (int t = 0; t < 4; t++) c[i][t] = frac(tot[t]);
            send_item(CMD_CLAIM, 3'(i), c[i][0], c[i][1], c[i][2], c[i][3]);
        end
        for (int i = 0; i < nprocs; i++)
            send_item(CMD_ALLOC, 3'(i), 8'(frac(c[i][0]) / nprocs), 8'(frac(c[i][1]) / nprocs),
                      8'(frac(c[i][2]) / nprocs), 8'(frac(c[i][3]) / nprocs));
        send_item(CMD_CHECK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
        repeat ($urandom_range(3, 1))
        begin
            if ($urandom_range(9) == 0)
                send_item(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            else
                send_item(CMD_REQ, 3'($urandom_range(nprocs - 1)), frac(8'd3), frac(8'd3),
                          frac(8'd3), frac(8'd3));
        end
    endtask

    initial
    begin
        tot = '{default: 0};
        nprocs = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_idle = 28;
        recv_idle = 69;

        // directed: out-of-range registers clamp, extremes of fields
        set_config(0, 0, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);
        set_config(15, 7, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(CMD_CLAIM, 7, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(CMD_ALLOC, 7, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);         // fully allocated check
        send_item(CMD_ALLOC, 0, 1, 0, 0, 0);         // alloc above claim
        send_item(CMD_CLAIM, 0, 8'h10, 8'h10, 8'h10, 8'h10);
        send_item(CMD_ALLOC, 0, 1, 1, 1, 1);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);         // over-allocation
        send_item(CMD_ALLOC, 7, 0, 0, 0, 0);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);
        send_item(CMD_REQ, 0, 1, 1, 1, 1);           // grant
        send_item(CMD_REQ, 0, 8'hff, 0, 0, 0);       // above need
        send_item(CMD_REQ, 5, 0, 0, 0, 0);
        set_config(2, 1, 8'd10, 8'd0, 8'd0, 8'd0);
        send_item(CMD_CLAIM, 0, 8'd20, 0, 0, 0);     // claim above total
        send_item(CMD_CLAIM, 0, 8'd10, 8'hff, 0, 0); // unused type stored
        send_item(CMD_CLAIM, 1, 8'd10, 0, 0, 0);
        send_item(CMD_ALLOC, 0, 8'd5, 0, 0, 0);
        send_item(CMD_ALLOC, 1, 8'd4, 0, 0, 0);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);         // unsafe check
        send_item(CMD_REQ, 1, 8'd1, 0, 0, 0);        // unsafe request
        send_item(CMD_REQ, 3, 0, 0, 0, 0);           // idle process
        send_item(CMD_ALLOC, 1, 8'd0, 0, 0, 0);
        send_item(CMD_CHECK, 0, 0, 0, 0, 0);
        send_item(CMD_REQ, 0, 8'd4, 0, 0, 0);        // granted request

        while (sent_count < 110)
        begin
            if (sent_count >= 80)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (sent_count >= 40)
            begin
                send_idle = 69;
                recv_idle = 28;
            end
            set_config(4'($urandom_range(8, 1)), 3'($urandom_range(4, 1)), 8'($urandom),
                       8'($urandom),
                       ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom),
                       ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
            scenario();
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
